>>> hdl/sre_pkg.sv
// Shared constants, types and control structs for the sprite RLE decoder.
// No dependencies; every other file in hdl/ uses this package.
package sre_pkg;

  localparam int MAX_DIM = 1024;
  localparam int CFG_W   = 11;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int AREA_W  = 2 * DIM_W;
  localparam int POS_W   = $clog2(MAX_DIM * MAX_DIM + MAX_DIM + 1);
  localparam int SUM_W   = DIM_W + 1;
  localparam int CNT_W   = $clog2(SUM_W);
  localparam int IDX_W   = 20;
  localparam int BYTE_W  = 8;
  localparam int RUN_W   = 7;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [BYTE_W-1:0] CODE_EOR = 8'd128;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD_NORM,
    S_MOD_SKIP,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_EOR,
    KIND_RUN
  } kind_t;

  typedef enum logic [0:0] {
    MOD_SRC_COL,
    MOD_SRC_SUM
  } mod_src_t;

  typedef struct packed {
    logic     load;
    logic     set_done;
    logic     norm_sub;
    logic     mod_start;
    mod_src_t mod_src;
    logic     mod_step;
    logic     do_literal;
    logic     do_run;
    logic     do_eor;
    logic     do_skip;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic  empty;
    logic  done;
    logic  col_ge_w;
    logic  col_lt_2w;
    logic  lit_nz;
    kind_t kind;
    logic  sum_lt_2w;
    logic  mod_last;
    logic  out_busy;
  } dp_status_t;

endpackage

>>> hdl/sre_code_if.sv
// Input channel: compressed sprite bytes with valid/ready handshake.
// Depends on sre_pkg for field widths.
interface sre_code_if;
  logic                        valid;
  logic                        ready;
  logic [sre_pkg::BYTE_W-1:0]  code_byte;
  logic                        first_byte;

  modport source(output valid, code_byte, first_byte, input ready);
  modport sink(input valid, code_byte, first_byte, output ready);
endinterface

>>> hdl/sre_pixel_if.sv
// Output channel: pixel write results with valid/ready handshake.
// Depends on sre_pkg for field widths.
interface sre_pixel_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [sre_pkg::IDX_W-1:0]   pixel_index;
  logic [sre_pkg::IDX_W-1:0]   mirror_index;
  logic [sre_pkg::BYTE_W-1:0]  pixel_value;
  logic                        frame_done;

  modport source(output valid, write_enable, pixel_index, mirror_index, pixel_value,
                 frame_done, input ready);
  modport sink(input valid, write_enable, pixel_index, mirror_index, pixel_value,
               frame_done, output ready);
endinterface

>>> hdl/sprite_rle_decoder_unit.sv
// Sprite run-length decoder top level: APB config, byte input, pixel write output.
// Depends on sre_pkg, sre_code_if, sre_pixel_if, sre_cfg, sre_ctrl, sre_dpath.
//
//   channel  dir  payload                                        transfer when
//   code     in   code_byte[7:0], first_byte                     valid & ready
//   pixel    out  write_enable, pixel_index[19:0],               valid & ready
//                 mirror_index[19:0], pixel_value[7:0], frame_done
//   apb      in   width (0x0), height (0x4), 11 bits each        psel & penable & pwrite
//
// One byte in flight; a byte passes through accept, execute and result hand-off.
// A column left at or above a narrowed width is brought back by one subtraction
// of the width when below twice the width, else by the bit-serial remainder unit;
// a skip that lands at or beyond twice the width is also reduced in that unit.
// Reset clears position, column, run count, done flag and the config registers.
// The next byte is taken while a result waits in the output register; a held
// result stalls only the hand-off of the following one.
module sprite_rle_decoder_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sre_pkg::ADDR_W-1:0]   paddr,
  input  logic [sre_pkg::DATA_W-1:0]   pwdata,
  output logic [sre_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  sre_code_if.sink                     code,
  sre_pixel_if.source                  pixel
);

  logic [sre_pkg::DIM_W-1:0]   width;
  logic [sre_pkg::AREA_W-1:0]  area;
  sre_pkg::dp_cmd_t            cmd;
  sre_pkg::dp_status_t         status;
  logic                        in_ready;

  assign code.ready = in_ready;

  sre_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .width   (width),
    .area    (area)
  );

  sre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (code.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  sre_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .width        (width),
    .area         (area),
    .code_byte    (code.code_byte),
    .first_byte   (code.first_byte),
    .out_ready    (pixel.ready),
    .out_valid    (pixel.valid),
    .write_enable (pixel.write_enable),
    .pixel_index  (pixel.pixel_index),
    .mirror_index (pixel.mirror_index),
    .pixel_value  (pixel.pixel_value),
    .frame_done   (pixel.frame_done)
  );

endmodule

>>> hdl/sre_cfg.sv
// APB register file: sprite width and height, clamped, plus registered area.
// Depends on sre_pkg.
module sre_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sre_pkg::ADDR_W-1:0]   paddr,
  input  logic [sre_pkg::DATA_W-1:0]   pwdata,
  output logic [sre_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output logic [sre_pkg::DIM_W-1:0]    width,
  output logic [sre_pkg::AREA_W-1:0]   area
);

  logic [sre_pkg::CFG_W-1:0]  width_reg;
  logic [sre_pkg::CFG_W-1:0]  height_reg;
  logic [sre_pkg::DIM_W-1:0]  height;
  sre_pkg::reg_idx_t          reg_idx;
  logic                       wr_en;

  assign reg_idx = sre_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= '0;
      height_reg <= '0;
      area       <= '0;
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          sre_pkg::REG_WIDTH:  width_reg  <= pwdata[sre_pkg::CFG_W-1:0];
          sre_pkg::REG_HEIGHT: height_reg <= pwdata[sre_pkg::CFG_W-1:0];
        endcase
      end
      area <= sre_pkg::AREA_W'(width) * sre_pkg::AREA_W'(height);
    end
  end

  assign width  = (width_reg > sre_pkg::CFG_W'(sre_pkg::MAX_DIM)) ?
                  sre_pkg::DIM_W'(sre_pkg::MAX_DIM) : sre_pkg::DIM_W'(width_reg);
  assign height = (height_reg > sre_pkg::CFG_W'(sre_pkg::MAX_DIM)) ?
                  sre_pkg::DIM_W'(sre_pkg::MAX_DIM) : sre_pkg::DIM_W'(height_reg);

  always_comb begin
    unique case (reg_idx)
      sre_pkg::REG_WIDTH:  prdata = sre_pkg::DATA_W'(width_reg);
      sre_pkg::REG_HEIGHT: prdata = sre_pkg::DATA_W'(height_reg);
    endcase
  end

endmodule

>>> hdl/sre_dpath.sv
// Decoder datapath: position/column/run state, remainder unit, result registers.
// Depends on sre_pkg; driven by sre_ctrl commands.
module sre_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  sre_pkg::dp_cmd_t             cmd,
  output sre_pkg::dp_status_t          status,
  input  logic [sre_pkg::DIM_W-1:0]    width,
  input  logic [sre_pkg::AREA_W-1:0]   area,
  input  logic [sre_pkg::BYTE_W-1:0]   code_byte,
  input  logic                         first_byte,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         write_enable,
  output logic [sre_pkg::IDX_W-1:0]    pixel_index,
  output logic [sre_pkg::IDX_W-1:0]    mirror_index,
  output logic [sre_pkg::BYTE_W-1:0]   pixel_value,
  output logic                         frame_done
);

  logic [sre_pkg::BYTE_W-1:0]  byte_q;
  logic [sre_pkg::POS_W-1:0]   pos;
  logic [sre_pkg::DIM_W-1:0]   col;
  logic [sre_pkg::RUN_W-1:0]   lit;
  logic                        done;

  logic                        res_we;
  logic [sre_pkg::IDX_W-1:0]   res_pix;
  logic [sre_pkg::IDX_W-1:0]   res_mir;
  logic [sre_pkg::BYTE_W-1:0]  res_val;

  logic [sre_pkg::SUM_W-1:0]   mod_dvd;
  logic [sre_pkg::DIM_W-1:0]   mod_rem;
  logic [sre_pkg::CNT_W-1:0]   mod_cnt;
  logic [sre_pkg::DIM_W:0]     mod_r2;
  logic [sre_pkg::DIM_W:0]     width_ext;
  logic [sre_pkg::DIM_W-1:0]   rem_next;
  logic                        mod_last;

  logic [sre_pkg::SUM_W-1:0]   sum;
  logic [sre_pkg::SUM_W-1:0]   sum_sub;
  logic [sre_pkg::SUM_W-1:0]   width_x2;
  logic [sre_pkg::DIM_W-1:0]   col_inc;
  logic [sre_pkg::POS_W-1:0]   mir_full;
  logic                        pos_ge_area;
  logic                        sum_lt_2w;

  assign width_ext   = {1'b0, width};
  assign width_x2    = {width, 1'b0};
  assign sum         = sre_pkg::SUM_W'(col) + sre_pkg::SUM_W'(byte_q);
  assign sum_sub     = sum - sre_pkg::SUM_W'(width);
  assign sum_lt_2w   = sum < width_x2;
  assign col_inc     = col + sre_pkg::DIM_W'(1);
  assign mir_full    = pos + sre_pkg::POS_W'(width) - sre_pkg::POS_W'(1)
                     - (sre_pkg::POS_W'(col) << 1);
  assign pos_ge_area = sre_pkg::AREA_W'(pos) >= area;

  // restoring remainder, one dividend bit per step
  assign mod_r2   = {mod_rem, mod_dvd[sre_pkg::SUM_W-1]};
  assign rem_next = (mod_r2 >= width_ext) ? sre_pkg::DIM_W'(mod_r2 - width_ext)
                                          : mod_r2[sre_pkg::DIM_W-1:0];
  assign mod_last = mod_cnt == sre_pkg::CNT_W'(sre_pkg::SUM_W - 1);

  always_comb begin
    status.empty     = area == '0;
    status.done      = done;
    status.col_ge_w  = col >= width;
    status.col_lt_2w = sre_pkg::SUM_W'(col) < width_x2;
    status.lit_nz    = lit != '0;
    status.sum_lt_2w = sum_lt_2w;
    status.mod_last  = mod_last;
    status.out_busy  = out_valid & ~out_ready;
    if (byte_q > sre_pkg::CODE_EOR) begin
      status.kind = sre_pkg::KIND_RUN;
    end else if (byte_q == sre_pkg::CODE_EOR) begin
      status.kind = sre_pkg::KIND_EOR;
    end else begin
      status.kind = sre_pkg::KIND_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      col       <= '0;
      lit       <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load && first_byte) begin
        pos  <= '0;
        col  <= '0;
        lit  <= '0;
        done <= 1'b0;
      end
      if (cmd.set_done) begin
        done <= 1'b1;
      end
      if (cmd.norm_sub) begin
        col <= col - width;
      end
      if (cmd.do_literal) begin
        lit <= lit - sre_pkg::RUN_W'(1);
        pos <= pos + sre_pkg::POS_W'(1);
        col <= (col_inc == width) ? '0 : col_inc;
      end
      if (cmd.do_run) begin
        lit <= byte_q[sre_pkg::RUN_W-1:0];
      end
      if (cmd.do_eor && col != '0) begin
        pos <= pos + sre_pkg::POS_W'(width - col);
        col <= '0;
      end
      if (cmd.do_skip) begin
        pos <= pos + sre_pkg::POS_W'(byte_q);
        if (sum < sre_pkg::SUM_W'(width)) begin
          col <= sum[sre_pkg::DIM_W-1:0];
        end else if (sum_lt_2w) begin
          col <= sum_sub[sre_pkg::DIM_W-1:0];
        end
      end
      if (cmd.mod_step && mod_last) begin
        col <= rem_next;
      end
      if (cmd.emit && pos_ge_area) begin
        done <= 1'b1;
        lit  <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q  <= code_byte;
      res_we  <= 1'b0;
      res_pix <= '0;
      res_mir <= '0;
      res_val <= '0;
    end
    if (cmd.do_literal) begin
      res_we  <= 1'b1;
      res_pix <= pos[sre_pkg::IDX_W-1:0];
      res_mir <= mir_full[sre_pkg::IDX_W-1:0];
      res_val <= byte_q;
    end
    if (cmd.mod_start) begin
      mod_dvd <= (cmd.mod_src == sre_pkg::MOD_SRC_COL) ? sre_pkg::SUM_W'(col) : sum;
      mod_rem <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_dvd <= mod_dvd << 1;
      mod_rem <= rem_next;
      mod_cnt <= mod_cnt + sre_pkg::CNT_W'(1);
    end
    if (cmd.emit) begin
      write_enable <= res_we;
      pixel_index  <= res_pix;
      mirror_index <= res_mir;
      pixel_value  <= res_val;
      frame_done   <= done | pos_ge_area;
    end
  end

endmodule

>>> hdl/sre_ctrl.sv
// Decoder sequencer: accepts a byte, steps the datapath, hands off the result.
// Depends on sre_pkg; commands sre_dpath.
module sre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sre_pkg::dp_status_t  status,
  output sre_pkg::dp_cmd_t     cmd
);

  sre_pkg::state_t state;
  sre_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sre_pkg::S_IDLE: begin
        if (in_valid && in_ready) state_next = sre_pkg::S_EXEC;
      end
      sre_pkg::S_EXEC: begin
        if (status.empty || status.done) begin
          state_next = sre_pkg::S_EMIT;
        end else if (status.col_ge_w) begin
          if (!status.col_lt_2w) state_next = sre_pkg::S_MOD_NORM;
        end else if (status.lit_nz) begin
          state_next = sre_pkg::S_EMIT;
        end else if (status.kind == sre_pkg::KIND_SKIP && !status.sum_lt_2w) begin
          state_next = sre_pkg::S_MOD_SKIP;
        end else begin
          state_next = sre_pkg::S_EMIT;
        end
      end
      sre_pkg::S_MOD_NORM: begin
        if (status.mod_last) state_next = sre_pkg::S_EXEC;
      end
      sre_pkg::S_MOD_SKIP: begin
        if (status.mod_last) state_next = sre_pkg::S_EMIT;
      end
      sre_pkg::S_EMIT: begin
        if (!status.out_busy) state_next = sre_pkg::S_IDLE;
      end
      default: state_next = sre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == sre_pkg::S_IDLE) && !rst;
    cmd      = '0;
    unique case (state)
      sre_pkg::S_IDLE: begin
        cmd.load = in_valid && in_ready;
      end
      sre_pkg::S_EXEC: begin
        if (status.empty || status.done) begin
          cmd.set_done = 1'b1;
        end else if (status.col_ge_w) begin
          if (status.col_lt_2w) begin
            cmd.norm_sub = 1'b1;
          end else begin
            cmd.mod_start = 1'b1;
            cmd.mod_src   = sre_pkg::MOD_SRC_COL;
          end
        end else if (status.lit_nz) begin
          cmd.do_literal = 1'b1;
        end else begin
          unique case (status.kind)
            sre_pkg::KIND_RUN: cmd.do_run = 1'b1;
            sre_pkg::KIND_EOR: cmd.do_eor = 1'b1;
            sre_pkg::KIND_SKIP: begin
              cmd.do_skip = 1'b1;
              if (!status.sum_lt_2w) begin
                cmd.mod_start = 1'b1;
                cmd.mod_src   = sre_pkg::MOD_SRC_SUM;
              end
            end
            default: cmd.do_skip = 1'b0;
          endcase
        end
      end
      sre_pkg::S_MOD_NORM, sre_pkg::S_MOD_SKIP: begin
        cmd.mod_step = 1'b1;
      end
      sre_pkg::S_EMIT: begin
        cmd.emit = !status.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/sre_checker.sv
// Port-level checks for sprite_rle_decoder_unit, attached by bind.
// Depends on sre_pkg for field widths.
module sre_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         write_enable,
  input logic [sre_pkg::IDX_W-1:0]    pixel_index,
  input logic [sre_pkg::IDX_W-1:0]    mirror_index,
  input logic [sre_pkg::BYTE_W-1:0]   pixel_value,
  input logic                         frame_done
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second byte taken while one is in flight");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> pixel_index == '0 && mirror_index == '0
                                   && pixel_value == '0)
    else $error("non-write result carries nonzero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_enable)
      && $stable(pixel_index) && $stable(mirror_index) && $stable(pixel_value)
      && $stable(frame_done))
    else $error("stalled result changed");

endmodule

bind sprite_rle_decoder_unit sre_checker u_sre_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (code.valid),
  .in_ready     (code.ready),
  .out_valid    (pixel.valid),
  .out_ready    (pixel.ready),
  .write_enable (pixel.write_enable),
  .pixel_index  (pixel.pixel_index),
  .mirror_index (pixel.mirror_index),
  .pixel_value  (pixel.pixel_value),
  .frame_done   (pixel.frame_done)
);
